@@ rtl/csmms_pkg.sv @@
// package for the complex stream min/max/sum/mean block
// shared widths, the per-block statistics record and the back-end state type
// no dependencies

package csmms_pkg;

    localparam int OUT_W       = 16;   // width of min/max/mean result parts
    localparam int SUM_W       = 32;   // width of the wrapped sums
    localparam int CNT_W       = 17;   // sample count, 1 .. 65536
    localparam int IN_TDATA_W  = 32;   // sample_re, sample_im
    localparam int OUT_FIELD_W = 4 * OUT_W + 2 * SUM_W + 2 * OUT_W + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;
    localparam int OUT_CNT_LSB = 4 * OUT_W + 2 * SUM_W + 2 * OUT_W;
    localparam int QDEPTH      = 2;    // finished blocks waiting for the divider
    localparam int DIV_STEPS   = SUM_W;

    // one finished block, handed from the front end to the back end
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum_im;
        logic [SUM_W-1:0] sum_re;
        logic [OUT_W-1:0] max_im;
        logic [OUT_W-1:0] max_re;
        logic [OUT_W-1:0] min_im;
        logic [OUT_W-1:0] min_re;
    } stat_rec_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_OUT
    } back_state_t;

endpackage

@@ rtl/csmms_front.sv @@
// front end: accepts samples, squares them, tracks min/max magnitude, sums and count
// closes a block into a csmms_pkg::stat_rec_t record for the queue
// depends on csmms_pkg

module csmms_front #(
    parameter int MAX_BLOCK   = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [csmms_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                             s_tlast,
    input  logic                             q_full,
    output logic                             q_push,
    output csmms_pkg::stat_rec_t             q_rec
);

    localparam int SB    = SAMPLE_BITS;
    localparam int SQ_W  = 2 * SB;
    localparam int MAG_W = 2 * SB + 1;

    // sample parts: the low SB bits of each field, zero-extended first and then taken as signed
    logic [SB+15:0]        re_wide;
    logic [SB+15:0]        im_wide;
    logic signed [SB-1:0]  re_in;
    logic signed [SB-1:0]  im_in;
    logic signed [SQ_W-1:0] sq_re_in;
    logic signed [SQ_W-1:0] sq_im_in;

    assign re_wide  = {{SB{1'b0}}, s_tdata[15:0]};
    assign im_wide  = {{SB{1'b0}}, s_tdata[31:16]};
    assign re_in    = re_wide[SB-1:0];
    assign im_in    = im_wide[SB-1:0];
    assign sq_re_in = re_in * re_in;
    assign sq_im_in = im_in * im_in;

    // stage a: registered sample and squares
    logic                  a_valid_reg;
    logic                  a_valid_next;
    logic signed [SB-1:0]  a_re_reg;
    logic signed [SB-1:0]  a_im_reg;
    logic [SQ_W-1:0]       a_sqre_reg;
    logic [SQ_W-1:0]       a_sqim_reg;
    logic                  a_last_reg;

    // block statistics
    logic signed [SB-1:0]            low_re_reg,  low_im_reg;
    logic signed [SB-1:0]            high_re_reg, high_im_reg;
    logic [MAG_W-1:0]                low_mag_reg, high_mag_reg;
    logic [csmms_pkg::SUM_W-1:0]     acc_re_reg,  acc_im_reg;
    logic [csmms_pkg::CNT_W-1:0]     seen_reg;

    logic [MAG_W-1:0]                mag;
    logic                            first;
    logic                            take_low;
    logic                            take_high;
    logic signed [SB-1:0]            low_re_next,  low_im_next;
    logic signed [SB-1:0]            high_re_next, high_im_next;
    logic [MAG_W-1:0]                low_mag_next, high_mag_next;
    logic [csmms_pkg::SUM_W-1:0]     acc_re_next,  acc_im_next;
    logic [csmms_pkg::CNT_W-1:0]     seen_next;
    logic                            b_end;
    logic                            b_fire;

    function automatic logic [csmms_pkg::OUT_W-1:0] to_out(input logic signed [SB-1:0] v);
        logic [SB+csmms_pkg::OUT_W-1:0] w;
        w = {{csmms_pkg::OUT_W{v[SB-1]}}, v};
        return w[csmms_pkg::OUT_W-1:0];
    endfunction

    assign mag       = MAG_W'(a_sqre_reg) + MAG_W'(a_sqim_reg);
    assign first     = (seen_reg == '0);
    assign take_low  = first || (mag < low_mag_reg);
    assign take_high = first || (mag > high_mag_reg);

    assign low_re_next   = take_low  ? a_re_reg : low_re_reg;
    assign low_im_next   = take_low  ? a_im_reg : low_im_reg;
    assign low_mag_next  = take_low  ? mag      : low_mag_reg;
    assign high_re_next  = take_high ? a_re_reg : high_re_reg;
    assign high_im_next  = take_high ? a_im_reg : high_im_reg;
    assign high_mag_next = take_high ? mag      : high_mag_reg;

    assign acc_re_next = acc_re_reg + {{(csmms_pkg::SUM_W-SB){a_re_reg[SB-1]}}, a_re_reg};
    assign acc_im_next = acc_im_reg + {{(csmms_pkg::SUM_W-SB){a_im_reg[SB-1]}}, a_im_reg};
    assign seen_next   = seen_reg + 1'b1;

    // an overlong block closes on its own
    assign b_end  = a_last_reg || (seen_next == csmms_pkg::CNT_W'(MAX_BLOCK));
    assign b_fire = a_valid_reg && (!b_end || !q_full);
    assign q_push = b_fire && b_end;

    assign s_tready = !a_valid_reg || b_fire;

    always_comb
    begin
        if (s_tvalid && s_tready)
        begin
            a_valid_next = 1'b1;
        end
        else if (b_fire)
        begin
            a_valid_next = 1'b0;
        end
        else
        begin
            a_valid_next = a_valid_reg;
        end
    end

    always_comb
    begin
        q_rec.count  = seen_next;
        q_rec.sum_re = acc_re_next;
        q_rec.sum_im = acc_im_next;
        q_rec.min_re = to_out(low_re_next);
        q_rec.min_im = to_out(low_im_next);
        q_rec.max_re = to_out(high_re_next);
        q_rec.max_im = to_out(high_im_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            acc_re_reg  <= '0;
            acc_im_reg  <= '0;
            seen_reg    <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            if (b_fire)
            begin
                if (b_end)
                begin
                    acc_re_reg <= '0;
                    acc_im_reg <= '0;
                    seen_reg   <= '0;
                end
                else
                begin
                    acc_re_reg <= acc_re_next;
                    acc_im_reg <= acc_im_next;
                    seen_reg   <= seen_next;
                end
            end
        end
    end

    // payload, no reset: a count of zero makes the next sample both min and max
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            a_re_reg   <= re_in;
            a_im_reg   <= im_in;
            a_sqre_reg <= sq_re_in;
            a_sqim_reg <= sq_im_in;
            a_last_reg <= s_tlast;
        end
        if (b_fire)
        begin
            low_re_reg   <= low_re_next;
            low_im_reg   <= low_im_next;
            low_mag_reg  <= low_mag_next;
            high_re_reg  <= high_re_next;
            high_im_reg  <= high_im_next;
            high_mag_reg <= high_mag_next;
        end
    end

endmodule

@@ rtl/csmms_fifo.sv @@
// short queue of finished block records between front and back end
// depends on csmms_pkg

module csmms_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  csmms_pkg::stat_rec_t wr_rec,
    output logic                 full,
    output logic                 valid,
    input  logic                 pop,
    output csmms_pkg::stat_rec_t rd_rec
);

    localparam int PTR_W = (csmms_pkg::QDEPTH > 1) ? $clog2(csmms_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(csmms_pkg::QDEPTH + 1);

    csmms_pkg::stat_rec_t mem [csmms_pkg::QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(csmms_pkg::QDEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign full   = (fill_reg == CNT_W'(csmms_pkg::QDEPTH));
    assign valid  = (fill_reg != '0);
    assign rd_rec = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_rec;
        end
    end

endmodule

@@ rtl/csmms_back.sv @@
// back end: bit-serial division of both sums by the count, saturation, output register
// depends on csmms_pkg

module csmms_back #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  csmms_pkg::stat_rec_t              q_rec,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [csmms_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int SUM_W  = csmms_pkg::SUM_W;
    localparam int CNT_W  = csmms_pkg::CNT_W;
    localparam int OUT_W  = csmms_pkg::OUT_W;
    localparam int STEP_W = $clog2(csmms_pkg::DIV_STEPS);
    localparam logic signed [SUM_W:0] SAT_HI = (SUM_W+1)'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_W:0] SAT_LO = -SAT_HI - 1;

    csmms_pkg::back_state_t state_reg, state_next;
    logic [STEP_W-1:0]      step_reg;
    csmms_pkg::stat_rec_t   rec_reg;
    logic [CNT_W-1:0]       rem_re_reg, rem_im_reg;
    logic [SUM_W-1:0]       quo_re_reg, quo_im_reg;
    logic                   neg_re_reg, neg_im_reg;
    logic [OUT_W-1:0]       avg_re_reg, avg_im_reg;

    logic [CNT_W:0]         sh_re, sh_im;
    logic                   ge_re, ge_im;
    logic [CNT_W-1:0]       rem_re_next, rem_im_next;
    logic [SUM_W-1:0]       quo_re_next, quo_im_next;
    logic                   last_step;

    function automatic logic [SUM_W-1:0] abs_sum(input logic [SUM_W-1:0] v);
        return v[SUM_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [OUT_W-1:0] sat_mean(input logic neg, input logic [SUM_W-1:0] q);
        logic [SUM_W:0]        m;
        logic signed [SUM_W:0] v;
        logic signed [SUM_W:0] r;
        m = {1'b0, q};
        v = neg ? (~m + 1'b1) : m;
        if (v > SAT_HI)
        begin
            r = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO;
        end
        else
        begin
            r = v;
        end
        return r[OUT_W-1:0];
    endfunction

    // restoring division step, one quotient bit per lane per cycle
    assign sh_re       = {rem_re_reg, quo_re_reg[SUM_W-1]};
    assign sh_im       = {rem_im_reg, quo_im_reg[SUM_W-1]};
    assign ge_re       = (sh_re >= {1'b0, rec_reg.count});
    assign ge_im       = (sh_im >= {1'b0, rec_reg.count});
    assign rem_re_next = ge_re ? CNT_W'(sh_re - {1'b0, rec_reg.count}) : sh_re[CNT_W-1:0];
    assign rem_im_next = ge_im ? CNT_W'(sh_im - {1'b0, rec_reg.count}) : sh_im[CNT_W-1:0];
    assign quo_re_next = {quo_re_reg[SUM_W-2:0], ge_re};
    assign quo_im_next = {quo_im_reg[SUM_W-2:0], ge_im};
    assign last_step   = (step_reg == STEP_W'(csmms_pkg::DIV_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            csmms_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = csmms_pkg::BK_DIV;
                end
            end
            csmms_pkg::BK_DIV:
            begin
                if (last_step)
                begin
                    state_next = csmms_pkg::BK_OUT;
                end
            end
            csmms_pkg::BK_OUT:
            begin
                if (m_tready)
                begin
                    state_next = csmms_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = csmms_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            csmms_pkg::BK_IDLE:
            begin
                q_pop    = q_valid;
                m_tvalid = 1'b0;
            end
            csmms_pkg::BK_OUT:
            begin
                q_pop    = 1'b0;
                m_tvalid = 1'b1;
            end
            default:
            begin
                q_pop    = 1'b0;
                m_tvalid = 1'b0;
            end
        endcase
    end

    assign m_tdata = {{csmms_pkg::OUT_PAD_W{1'b0}}, rec_reg.count, avg_im_reg, avg_re_reg,
                      rec_reg.sum_im, rec_reg.sum_re, rec_reg.max_im, rec_reg.max_re,
                      rec_reg.min_im, rec_reg.min_re};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csmms_pkg::BK_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop || last_step)
            begin
                step_reg <= '0;
            end
            else if (state_reg == csmms_pkg::BK_DIV)
            begin
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rec_reg    <= q_rec;
            rem_re_reg <= '0;
            rem_im_reg <= '0;
            quo_re_reg <= abs_sum(q_rec.sum_re);
            quo_im_reg <= abs_sum(q_rec.sum_im);
            neg_re_reg <= q_rec.sum_re[SUM_W-1];
            neg_im_reg <= q_rec.sum_im[SUM_W-1];
        end
        else if (state_reg == csmms_pkg::BK_DIV)
        begin
            rem_re_reg <= rem_re_next;
            rem_im_reg <= rem_im_next;
            quo_re_reg <= quo_re_next;
            quo_im_reg <= quo_im_next;
            if (last_step)
            begin
                avg_re_reg <= sat_mean(neg_re_reg, quo_re_next);
                avg_im_reg <= sat_mean(neg_im_reg, quo_im_next);
            end
        end
    end

endmodule

@@ rtl/complex_stream_min_max_sum_mean_top.sv @@
// top level of the complex block statistics unit: min/max magnitude, sums, mean
// instantiates csmms_front, csmms_fifo and csmms_back; depends on csmms_pkg
//
//  channel | signals                            | moves
//  --------+------------------------------------+-----------------------------------------
//  slave   | s_tvalid s_tready s_tdata s_tlast  | one complex sample, tlast = block_end
//  master  | m_tvalid m_tready m_tdata          | one block result: min, max, sums, mean, count
//
//  flow: the front end takes one sample per cycle while s_tready is high; a sample passes a square
//  stage and an update stage. the back end takes one record, runs its shift-subtract divider,
//  then holds the result until taken, and only then takes the next record.
//  stalls: up to two finished blocks wait in the queue; only a block end meeting a full
//  queue stalls s_tready.
//  reset: rst_n clears all control state at once; there is no clearing pass.

module complex_stream_min_max_sum_mean_top #(
    parameter int MAX_BLOCK   = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [csmms_pkg::IN_TDATA_W-1:0]  s_tdata,   // sample_re[15:0], sample_im[31:16]
    input  logic                              s_tlast,   // block_end
    // block result
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // min_re, min_im, max_re, max_im (16 each), total_re, total_im (32 each),
    // avg_re, avg_im (16 each), sample_count (17), zero pad to 184 bits
    output logic [csmms_pkg::OUT_TDATA_W-1:0] m_tdata
);

    logic                 q_push;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    csmms_pkg::stat_rec_t q_wr_rec;
    csmms_pkg::stat_rec_t q_rd_rec;

    // classify and accumulate, close a record on block end or overlong block
    csmms_front #(
        .MAX_BLOCK   (MAX_BLOCK),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_rec    (q_wr_rec)
    );

    // decouples the per-sample front from the per-block divider
    csmms_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_rec (q_wr_rec),
        .full   (q_full),
        .valid  (q_valid),
        .pop    (q_pop),
        .rd_rec (q_rd_rec)
    );

    // mean by serial division, saturation, result register
    csmms_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_rec    (q_rd_rec),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // a finished block never lands on a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("block record pushed into full queue");

    // the back end only takes records that exist
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("record popped from empty queue");

    // the divider runs before any result shows
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> !m_tvalid)
        else $error("result shown without division");

    // a shown result counts between one and the block limit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            (m_tdata[csmms_pkg::OUT_CNT_LSB +: csmms_pkg::CNT_W] != '0) &&
            (m_tdata[csmms_pkg::OUT_CNT_LSB +: csmms_pkg::CNT_W] <=
             csmms_pkg::CNT_W'(MAX_BLOCK)))
        else $error("result sample count out of range");

endmodule
